// ----- rtl/core/psg_pkg.sv -----
// Shared definitions for the three-channel sound generator voice.
// Register map codes, item opcodes, volume table and the envelope control word.
// No dependencies.
`timescale 1ns / 1ps

package psg_pkg;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register map
    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam int NUM_REGS  = 16;
    localparam int NUM_TONES = 3;

    // envelope shape bits
    localparam int SHAPE_HOLD   = 0;
    localparam int SHAPE_ALT    = 1;
    localparam int SHAPE_ATTACK = 2;
    localparam int SHAPE_CONT   = 3;

    localparam logic [3:0] LEVEL_MAX = 4'hf;
    localparam logic [3:0] LEVEL_MIN = 4'h0;

    // control word from the voice to the envelope unit
    typedef struct packed {
        logic        tick;
        logic        restart;
        logic        restart_attack;
        logic [3:0]  shape;
        logic [15:0] period;
    } t_env_ctrl;

    // logarithmic volume curve, 4-bit level to 6-bit amplitude
    function automatic logic [5:0] vol_lookup(input logic [3:0] level);
        logic [5:0] v;
        case (level)
            4'd0:    v = 6'd0;
            4'd1:    v = 6'd1;
            4'd2:    v = 6'd2;
            4'd3:    v = 6'd3;
            4'd4:    v = 6'd4;
            4'd5:    v = 6'd5;
            4'd6:    v = 6'd7;
            4'd7:    v = 6'd10;
            4'd8:    v = 6'd13;
            4'd9:    v = 6'd18;
            4'd10:   v = 6'd24;
            4'd11:   v = 6'd30;
            4'd12:   v = 6'd36;
            4'd13:   v = 6'd40;
            4'd14:   v = 6'd42;
            4'd15:   v = 6'd42;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/psg_env.sv -----
// Envelope generator: period divider, 16-step ramp, attack/alternate/hold logic.
// Depends on psg_pkg (t_env_ctrl, shape bit positions, level limits).
`timescale 1ns / 1ps

module psg_env import psg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_env_ctrl  i_ctrl,
    output logic [3:0] o_level
);

    logic [20:0] r_count;
    logic [4:0]  r_step;
    logic        r_attack;
    logic [3:0]  r_level;

    logic [20:0] n_count;
    logic [4:0]  n_step;
    logic        n_attack;
    logic [3:0]  n_level;

    logic [15:0] per;
    logic [20:0] cnt_inc;
    logic        fire;

    // zero period counts as one; divider compares against period * 32
    assign per     = (i_ctrl.period == 16'd0) ? 16'd1 : i_ctrl.period;
    assign cnt_inc = r_count + 21'd1;
    assign fire    = (cnt_inc >= {per, 5'b00000});

    // next state
    always_comb begin
        n_count  = r_count;
        n_step   = r_step;
        n_attack = r_attack;
        n_level  = r_level;
        if (i_ctrl.restart) begin
            n_count  = 21'd0;
            n_step   = 5'd0;
            n_attack = i_ctrl.restart_attack;
            n_level  = i_ctrl.restart_attack ? LEVEL_MIN : LEVEL_MAX;
        end else if (i_ctrl.tick) begin
            if (fire) begin
                n_count = 21'd0;
                if (!r_step[4]) begin
                    // ramp in progress
                    n_level = r_attack ? r_step[3:0] : ~r_step[3:0];
                    n_step  = r_step + 5'd1;
                end else if (!i_ctrl.shape[SHAPE_CONT]) begin
                    n_level = LEVEL_MIN;
                end else if (i_ctrl.shape[SHAPE_HOLD]) begin
                    n_level = (r_attack ^ i_ctrl.shape[SHAPE_ALT]) ? LEVEL_MAX : LEVEL_MIN;
                end else begin
                    // repeat, flipping direction when alternating
                    n_attack = r_attack ^ i_ctrl.shape[SHAPE_ALT];
                    n_step   = 5'd0;
                    n_level  = n_attack ? LEVEL_MIN : LEVEL_MAX;
                end
            end else begin
                n_count = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 21'd0;
            r_step   <= 5'd0;
            r_attack <= 1'b0;
            r_level  <= 4'd0;
        end else begin
            r_count  <= n_count;
            r_step   <= n_step;
            r_attack <= n_attack;
            r_level  <= n_level;
        end
    end

    assign o_level = n_level;

endmodule

// ----- rtl/core/psg_tone_noise_envelope_voice.sv -----
// Top level of the three-channel sound generator voice.
// Depends on psg_pkg and psg_env.
`timescale 1ns / 1ps

// Each input word is either a register write (opcode 0) or one generator tick
// (opcode 1); every word yields exactly one output word carrying the mixed
// amplitude (0..126) after that word has taken effect. The block takes one
// word per clock whenever the output side is not stalled: a word is held in
// the input register until it can advance, and the state update plus volume
// mix are then registered into the output register. Writing register 13
// restarts the envelope.
module psg_tone_noise_envelope_voice import psg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [3:0] i_reg_index,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_amplitude
);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [3:0] r_in_idx;
    logic [7:0] r_in_data;

    // output register
    logic       r_out_valid;
    logic [6:0] r_out_amp;

    // generator state
    logic [7:0]  r_regs [NUM_REGS];
    logic [11:0] r_tone_count [NUM_TONES];
    logic [2:0]  r_tone_level;
    logic [5:0]  r_noise_count;
    logic [16:0] r_noise_shift;
    logic        r_noise_level;

    logic [7:0]  n_regs [NUM_REGS];
    logic [11:0] n_tone_count [NUM_TONES];
    logic [2:0]  n_tone_level;
    logic [5:0]  n_noise_count;
    logic [16:0] n_noise_shift;
    logic        n_noise_level;
    logic [6:0]  n_amp;

    logic        advance;
    logic        in_accept;
    logic        is_tick;
    logic        is_write;
    t_env_ctrl   env_ctrl;
    logic [3:0]  env_level;

    // handshake: a word moves on when the output register is free or draining
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign is_tick   = advance && (r_in_op == OP_TICK);
    assign is_write  = advance && (r_in_op == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= i_opcode;
            r_in_idx  <= i_reg_index;
            r_in_data <= i_write_data;
        end
    end

    // register file writes
    always_comb begin
        for (int r = 0; r < NUM_REGS; r++) begin
            n_regs[r] = r_regs[r];
        end
        if (is_write) begin
            n_regs[r_in_idx] = r_in_data;
        end
    end

    // tone dividers, one per channel
    always_comb begin
        logic [11:0] inc;
        logic [11:0] per;
        for (int c = 0; c < NUM_TONES; c++) begin
            n_tone_count[c] = r_tone_count[c];
            n_tone_level[c] = r_tone_level[c];
            inc = r_tone_count[c] + 12'd1;
            per = {r_regs[2*c+1][3:0], r_regs[2*c]};
            if (per == 12'd0) begin
                per = 12'd1;
            end
            if (is_tick) begin
                if (inc >= per) begin
                    n_tone_count[c] = 12'd0;
                    n_tone_level[c] = ~r_tone_level[c];
                end else begin
                    n_tone_count[c] = inc;
                end
            end
        end
    end

    // noise divider and 17-bit LFSR
    always_comb begin
        logic [5:0] inc;
        logic [4:0] per;
        n_noise_count = r_noise_count;
        n_noise_shift = r_noise_shift;
        n_noise_level = r_noise_level;
        inc = r_noise_count + 6'd1;
        per = r_regs[REG_NOISE_PER][4:0];
        if (per == 5'd0) begin
            per = 5'd1;
        end
        if (is_tick) begin
            if (inc >= {per, 1'b0}) begin
                n_noise_count = 6'd0;
                n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[3], r_noise_shift[16:1]};
                n_noise_level = r_noise_shift[1];
            end else begin
                n_noise_count = inc;
            end
        end
    end

    // envelope unit
    always_comb begin
        env_ctrl.tick           = is_tick;
        env_ctrl.restart        = is_write && (r_in_idx == REG_ENV_SHAPE);
        env_ctrl.restart_attack = r_in_data[SHAPE_ATTACK];
        env_ctrl.shape          = r_regs[REG_ENV_SHAPE][3:0];
        env_ctrl.period         = {r_regs[REG_ENV_HI], r_regs[REG_ENV_LO]};
    end

    psg_env u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (env_ctrl),
        .o_level (env_level)
    );

    // gating and volume mix on the updated state
    always_comb begin
        logic       tone_ok;
        logic       noise_ok;
        logic [7:0] vr;
        logic [3:0] lvl;
        n_amp = 7'd0;
        for (int c = 0; c < NUM_TONES; c++) begin
            tone_ok  = n_regs[REG_MIXER][c] | n_tone_level[c];
            noise_ok = n_regs[REG_MIXER][c+3] | n_noise_level;
            vr       = n_regs[REG_VOL_A + 4'(c)];
            lvl      = vr[4] ? env_level : vr[3:0];
            if (tone_ok && noise_ok) begin
                n_amp = n_amp + {1'b0, vol_lookup(lvl)};
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_regs[r] <= 8'd0;
            end
            for (int c = 0; c < NUM_TONES; c++) begin
                r_tone_count[c] <= 12'd0;
            end
            r_tone_level  <= 3'd0;
            r_noise_count <= 6'd0;
            r_noise_shift <= 17'd1;
            r_noise_level <= 1'b0;
        end else begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_regs[r] <= n_regs[r];
            end
            for (int c = 0; c < NUM_TONES; c++) begin
                r_tone_count[c] <= n_tone_count[c];
            end
            r_tone_level  <= n_tone_level;
            r_noise_count <= n_noise_count;
            r_noise_shift <= n_noise_shift;
            r_noise_level <= n_noise_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_amp <= n_amp;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_amplitude = r_out_amp;

endmodule

// ----- dv/psg_tone_noise_envelope_voice_tb.sv -----
// Self-checking testbench for the three-channel sound generator voice.
// Depends on psg_pkg and psg_tone_noise_envelope_voice; predicts every output word in-bench.
`timescale 1ns / 1ps

module psg_tone_noise_envelope_voice_tb;
    import psg_pkg::*;

    // register indexes the package does not name
    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [3:0] REG_VOL_B         = 4'd9;
    localparam logic [3:0] REG_VOL_C         = 4'd10;
    localparam logic [3:0] REG_SPARE_A       = 4'd14;
    localparam logic [3:0] REG_SPARE_B       = 4'd15;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 100;

    localparam logic [5:0] VOL_CURVE [16] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7, 6'd10,
        6'd13, 6'd18, 6'd24, 6'd30, 6'd36, 6'd40, 6'd42, 6'd42
    };

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_opcode     = OP_WRITE;
    logic [3:0] i_reg_index  = 4'd0;
    logic [7:0] i_write_data = 8'd0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_amplitude;

    psg_tone_noise_envelope_voice dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_amplitude  (o_amplitude)
    );

    // voice state mirrored in the bench
    logic [7:0]  voice_regs [NUM_REGS];
    logic [11:0] tone_cnt [NUM_TONES];
    logic [2:0]  tone_lvl;
    logic [5:0]  noise_cnt;
    logic [16:0] noise_lfsr;
    logic        noise_bit;
    logic [20:0] env_cnt;
    logic [4:0]  env_step;
    logic        env_attack;
    logic [3:0]  env_level;

    logic [6:0] expected_amplitudes [$];
    int         errors = 0;
    int         quiet_cycles = 0;
    bit         send_idle_on = 1'b1;
    bit         recv_idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_voice_state();
        int k;
        for (k = 0; k < NUM_REGS; k++) voice_regs[k] = 8'd0;
        for (k = 0; k < NUM_TONES; k++) tone_cnt[k] = 12'd0;
        tone_lvl   = 3'b000;
        noise_cnt  = 6'd0;
        noise_lfsr = 17'd1;
        noise_bit  = 1'b0;
        env_cnt    = 21'd0;
        env_step   = 5'd0;
        env_attack = 1'b0;
        env_level  = LEVEL_MIN;
    endtask

    // advance the mirrored voice by one word and return the mixed amplitude
    task automatic apply_word(input logic op, input logic [3:0] idx, input logic [7:0] data,
                              output logic [6:0] amp);
        int         c;
        int         per;
        int         sum;
        logic [3:0] lvl;
        logic [7:0] shape;
        if (op == OP_TICK) begin
            for (c = 0; c < NUM_TONES; c++) begin
                tone_cnt[c] = tone_cnt[c] + 12'd1;
                per = {voice_regs[2*c+1][3:0], voice_regs[2*c]};
                if (per == 0) per = 1;
                if (int'(tone_cnt[c]) >= per) begin
                    tone_cnt[c] = 12'd0;
                    tone_lvl[c] = ~tone_lvl[c];
                end
            end
            // noise divider runs at half rate
            noise_cnt = noise_cnt + 6'd1;
            per = voice_regs[REG_NOISE_PER][4:0];
            if (per == 0) per = 1;
            if (int'(noise_cnt) >= 2 * per) begin
                noise_cnt  = 6'd0;
                noise_lfsr = {noise_lfsr[0] ^ noise_lfsr[3], noise_lfsr[16:1]};
                noise_bit  = noise_lfsr[0];
            end
            // envelope divider, 32 ticks per period unit
            env_cnt = env_cnt + 21'd1;
            per = {voice_regs[REG_ENV_HI], voice_regs[REG_ENV_LO]};
            if (per == 0) per = 1;
            if (int'(env_cnt) >= 32 * per) begin
                shape   = voice_regs[REG_ENV_SHAPE];
                env_cnt = 21'd0;
                if (env_step < 5'd16) begin
                    env_level = env_attack ? env_step[3:0] : LEVEL_MAX - env_step[3:0];
                    env_step  = env_step + 5'd1;
                end else if (!shape[SHAPE_CONT]) begin
                    env_level = LEVEL_MIN;
                end else if (shape[SHAPE_HOLD]) begin
                    env_level = (env_attack ^ shape[SHAPE_ALT]) ? LEVEL_MAX : LEVEL_MIN;
                end else begin
                    if (shape[SHAPE_ALT]) env_attack = ~env_attack;
                    env_step  = 5'd0;
                    env_level = env_attack ? LEVEL_MIN : LEVEL_MAX;
                end
            end
        end else begin
            voice_regs[idx] = data;
            if (idx == REG_ENV_SHAPE) begin
                env_step   = 5'd0;
                env_cnt    = 21'd0;
                env_attack = data[SHAPE_ATTACK];
                env_level  = env_attack ? LEVEL_MIN : LEVEL_MAX;
            end
        end
        // gate and sum the three channels
        sum = 0;
        for (c = 0; c < NUM_TONES; c++) begin
            if ((voice_regs[REG_MIXER][c] || tone_lvl[c]) &&
                (voice_regs[REG_MIXER][c+3] || noise_bit)) begin
                lvl = voice_regs[REG_VOL_A + c][4] ? env_level : voice_regs[REG_VOL_A + c][3:0];
                sum += VOL_CURVE[lvl];
            end
        end
        amp = sum[6:0];
    endtask

    // predict on every accepted input word, compare on every accepted output word
    always @(posedge i_clk) begin : amplitude_check
        logic [6:0] amp;
        logic [6:0] want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                apply_word(i_opcode, i_reg_index, i_write_data, amp);
                expected_amplitudes.push_back(amp);
            end
            if (o_valid && !i_stall) begin
                if (expected_amplitudes.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: output word with none outstanding, expected none, actual %0d",
                                 $time, o_amplitude);
                end else begin
                    want = expected_amplitudes.pop_front();
                    if (o_amplitude !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: amplitude mismatch, expected %0d, actual %0d",
                                     $time, want, o_amplitude);
                    end
                end
            end
        end
    end

    // output side back-pressure, drawn after each accepted word
    always @(posedge i_clk) begin : output_stall
        int stall_left;
        int n;
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= (stall_left > 0);
        end else if (o_valid && !i_stall) begin
            if ($urandom_range(0, 29) == 0) recv_idle_on = ~recv_idle_on;
            n = recv_idle_on ? $urandom_range(0, 8) : 0;
            stall_left = n;
            i_stall <= (n > 0);
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one word, hold it until accepted
    task automatic send_word(input logic op, input logic [3:0] idx, input logic [7:0] data);
        int gap;
        if ($urandom_range(0, 39) == 0) send_idle_on = ~send_idle_on;
        gap = send_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_reg_index  <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (o_stall);
    endtask

    // tick with junk in the ignored fields
    task automatic send_tick();
        send_word(OP_TICK, 4'($urandom), 8'($urandom));
    endtask

    // run a number of ticks with occasional register writes mixed in
    task automatic run_ticks(input int n, input bit allow_restart);
        int         ticks;
        logic [3:0] idx;
        logic [7:0] val;
        ticks = 0;
        while (ticks < n) begin
            if ($urandom_range(0, 23) == 0) begin
                idx = 4'($urandom);
                val = 8'($urandom);
                // keep the envelope fast so its steps are reached
                if (idx == REG_ENV_LO) val = 8'($urandom_range(0, 1));
                if (idx == REG_ENV_HI) val = 8'h00;
                if (idx == REG_ENV_SHAPE && !allow_restart) idx = REG_MIXER;
                send_word(OP_WRITE, idx, val);
            end else begin
                send_tick();
                ticks++;
            end
        end
    endtask

    // random tone, noise, mixer and volume setup with a short envelope period
    task automatic setup_voice(input int env_max);
        int c;
        for (c = 0; c < NUM_TONES; c++) begin
            send_word(OP_WRITE, 4'(REG_TONE_A_FINE + 2 * c),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
            send_word(OP_WRITE, 4'(REG_TONE_A_COARSE + 2 * c),
                      ($urandom_range(0, 5) == 0) ? 8'($urandom) : {4'($urandom), 4'h0});
        end
        send_word(OP_WRITE, REG_NOISE_PER, 8'($urandom));
        send_word(OP_WRITE, REG_MIXER, 8'($urandom));
        for (c = 0; c < NUM_TONES; c++)
            send_word(OP_WRITE, 4'(REG_VOL_A + c),
                      ($urandom_range(0, 2) != 0) ? (8'($urandom) | 8'h10) : 8'($urandom));
        send_word(OP_WRITE, REG_ENV_LO, 8'($urandom_range(0, env_max)));
        send_word(OP_WRITE, REG_ENV_HI, 8'h00);
    endtask

    // straight out of reset every period is zero and counts as one
    task automatic test_zero_period();
        send_word(OP_TICK, REG_SPARE_B, 8'hff);
        send_word(OP_TICK, 4'd0, 8'h00);
        send_tick();
    endtask

    // mixer bypass, a fixed volume and envelope-driven volumes
    task automatic test_mixer_and_volume();
        send_word(OP_WRITE, REG_MIXER, 8'hff);
        send_word(OP_WRITE, REG_VOL_A, 8'h0f);
        send_word(OP_WRITE, REG_VOL_B, 8'h10);
        send_word(OP_WRITE, REG_VOL_C, 8'hff);
        send_tick();
        send_word(OP_WRITE, REG_MIXER, 8'h00);
    endtask

    // long tone period, let it count, then cut it below the count
    task automatic test_period_shortened();
        send_word(OP_WRITE, REG_TONE_A_FINE, 8'hff);
        send_word(OP_WRITE, REG_TONE_A_COARSE, 8'hff);
        send_tick();
        send_tick();
        send_word(OP_WRITE, REG_TONE_A_COARSE, 8'h00);
        send_word(OP_WRITE, REG_TONE_A_FINE, 8'h01);
    endtask

    // shape writes restart the envelope in attack and in decay
    task automatic test_envelope_restart();
        send_word(OP_WRITE, REG_ENV_LO, 8'hff);
        send_word(OP_WRITE, REG_ENV_HI, 8'hff);
        send_word(OP_WRITE, REG_ENV_SHAPE, 8'hff);
        send_tick();
        send_word(OP_WRITE, REG_ENV_SHAPE, 8'h00);
        send_word(OP_WRITE, REG_ENV_HI, 8'h00);
    endtask

    // spare registers and the widest noise period
    task automatic test_spare_registers();
        send_word(OP_WRITE, REG_SPARE_A, 8'hff);
        send_word(OP_WRITE, REG_SPARE_B, 8'h55);
        send_word(OP_WRITE, REG_NOISE_PER, 8'hff);
    endtask

    // run each envelope ending to completion: stop, hold, repeat (alternate drawn at random)
    task automatic test_envelope_endings();
        int         kind;
        logic [7:0] shape;
        for (kind = 0; kind < 3; kind++) begin
            setup_voice(1);
            shape = 8'($urandom);
            case (kind)
                0: begin
                    shape[SHAPE_CONT] = 1'b0;
                end
                1: begin
                    shape[SHAPE_CONT] = 1'b1;
                    shape[SHAPE_HOLD] = 1'b1;
                end
                default: begin
                    shape[SHAPE_CONT] = 1'b1;
                    shape[SHAPE_HOLD] = 1'b0;
                end
            endcase
            send_word(OP_WRITE, REG_ENV_SHAPE, shape);
            // end of ramp comes at 17 steps; repeats need two more periods to show
            run_ticks((kind < 2) ? $urandom_range(550, 570) : $urandom_range(610, 630), 1'b0);
        end
    endtask

    // unstructured words: any opcode, register and byte
    task automatic test_random_noise();
        int k;
        for (k = 0; k < 40; k++)
            send_word(1'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // short random programs with restarts allowed
    task automatic test_short_programs();
        int k;
        for (k = 0; k < 2; k++) begin
            setup_voice(3);
            send_word(OP_WRITE, REG_ENV_SHAPE, 8'($urandom));
            run_ticks($urandom_range(20, 60), 1'b1);
        end
    endtask

    initial begin
        clear_voice_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_period();
        test_mixer_and_volume();
        test_period_shortened();
        test_envelope_restart();
        test_spare_registers();
        test_envelope_endings();
        test_random_noise();
        test_short_programs();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_amplitudes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_amplitudes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
